// File: hdl/hptc_pkg.sv
package hptc_pkg;

	// result status codes
	localparam logic [2:0] ST_MERGED = 3'd0;
	localparam logic [2:0] ST_NEW    = 3'd1;
	localparam logic [2:0] ST_FULL   = 3'd2;
	localparam logic [2:0] ST_ZERO   = 3'd3;
	localparam logic [2:0] ST_CLUS   = 3'd4;
	localparam logic [2:0] ST_EMPTY  = 3'd5;

	localparam logic [0:0] REQ_HIT   = 1'b0;
	localparam logic [0:0] REQ_FLUSH = 1'b1;

	localparam logic [0:0] REG_TIME_WINDOW = 1'b0;
	localparam logic [19:0] TIME_WINDOW_RST = 20'd80;

	localparam logic [55:0] SET_MAX = {56{1'b1}};
	localparam logic signed [47:0] POS_SUM_MAX = {1'b0, {47{1'b1}}};
	localparam logic signed [47:0] POS_SUM_MIN = {1'b1, {47{1'b0}}};
	localparam logic [19:0] T_MAX = {20{1'b1}};

	typedef struct packed {
		logic [31:0]        se;
		logic [55:0]        set;
		logic [63:0]        sq;
		logic signed [47:0] sx;
		logic signed [47:0] sy;
		logic signed [47:0] sz;
		logic [15:0]        hits;
	} slot_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [6:0]  ch;
		logic [19:0] mt;
		logic [19:0] sp;
		logic [31:0] esum;
		logic [15:0] mx;
		logic [15:0] my;
		logic [15:0] mz;
		logic [15:0] hits;
		logic        last;
	} res_t;

endpackage

// File: hdl/hptc_div.sv
// restoring divider, one quotient bit per cycle
module hptc_div import hptc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic [63:0] quotient,
	output logic        done
);

	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [63:0] dvd_q;
	logic [31:0] rem_q;
	logic [31:0] div_q;
	logic        done_q;
	logic [32:0] rem2;
	logic        ge;

	assign rem2 = {rem_q, dvd_q[63]};
	assign ge   = rem2 >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == '0)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? 32'(rem2 - {1'b0, div_q}) : rem2[31:0];
			dvd_q <= {dvd_q[62:0], ge};
		end
	end

	assign quotient = dvd_q;
	assign done     = done_q;

endmodule

// File: hdl/hptc_isqrt.sv
// integer square root, one result bit per cycle
module hptc_isqrt import hptc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic [31:0] root,
	output logic        done
);

	logic        busy_q;
	logic [4:0]  cnt_q;
	logic [63:0] rad_q;
	logic [34:0] rem_q;
	logic [31:0] root_q;
	logic        done_q;
	logic [34:0] rem2;
	logic [34:0] trial;
	logic        ge;

	assign rem2  = {rem_q[32:0], rad_q[63:62]};
	assign trial = {1'b0, root_q, 2'b01};
	assign ge    = rem2 >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == '0)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? rem2 - trial : rem2;
			root_q <= {root_q[30:0], ge};
			rad_q  <= {rad_q[61:0], 2'b00};
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule

// File: hdl/per_channel_hit_time_clustering_core.sv
// channel   dir  handshake                 payload
// s_axis    in   s_axis_tvalid/tready      tuser req_type, tdata hit fields
// m_axis    out  m_axis_tvalid/tready      tuser status, tlast, tdata result
// apb       in   psel/penable/pready       time_window at address 0
//
// A hit walks the channel's clusters, each through a slot memory read, a
// multiply and a compare, and is then accepted and its slot updated. A flush
// reads each cluster in turn and waits for the dividers and, where the spread
// needs it, the root before it pushes that cluster's result.
// The cluster table needs no clearing pass; per-channel counts have valid bits
// cleared at reset. One item is worked at a time; the result register lets the
// next item enter while a result waits, and the block stalls only to push a
// result while the previous one is still held.
module per_channel_hit_time_clustering_core import hptc_pkg::*; #(
	parameter int NUM_CHANNELS = 128,
	parameter int MAX_CLUSTERS = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [6:0] channel, [26:7] hit_time, [42:27] hit_energy, [58:43] pos_x,
	// [74:59] pos_y, [90:75] pos_z, [95:91] zero
	input  logic [95:0]  s_axis_tdata,
	// [0] req_type
	input  logic [0:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [6:0] out_channel, [26:7] mean_time, [46:27] time_spread,
	// [78:47] energy_sum, [94:79] mean_x, [110:95] mean_y, [126:111] mean_z,
	// [142:127] hit_count, [143] zero
	output logic [143:0] m_axis_tdata,
	// [2:0] status
	output logic [2:0]   m_axis_tuser,
	output logic         m_axis_tlast,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int NCH   = (NUM_CHANNELS < 128) ? NUM_CHANNELS : 128;
	localparam int CH_AW = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int NSLOT = NCH * MAX_CLUSTERS;
	localparam int SL_AW = (NSLOT > 1) ? $clog2(NSLOT) : 1;
	localparam int K_W   = $clog2(MAX_CLUSTERS + 1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CNT   = 4'd1;
	localparam logic [3:0] S_RDI   = 4'd2;
	localparam logic [3:0] S_RD    = 4'd3;
	localparam logic [3:0] S_CMP   = 4'd4;
	localparam logic [3:0] S_MUL1  = 4'd5;
	localparam logic [3:0] S_MUL2  = 4'd6;
	localparam logic [3:0] S_WR    = 4'd7;
	localparam logic [3:0] S_OUT   = 4'd8;
	localparam logic [3:0] S_FRD   = 4'd9;
	localparam logic [3:0] S_FDIV  = 4'd10;
	localparam logic [3:0] S_FSQ1  = 4'd11;
	localparam logic [3:0] S_FSQ2  = 4'd12;
	localparam logic [3:0] S_FSQRT = 4'd13;
	localparam logic [3:0] S_FRES  = 4'd14;

	logic [3:0] state_q, ret_q;
	logic [19:0] tw_q;

	// latched request
	logic [0:0]         req_q;
	logic [6:0]         ch_q;
	logic [19:0]        t_q;
	logic [15:0]        e_q;
	logic signed [15:0] px_q, py_q, pz_q;
	logic               in_rng_q;

	logic [K_W-1:0] n_q, k_q;
	logic           new_q;

	// channel count memory with valid bits
	logic [K_W-1:0] cnt_mem [NCH];
	logic [NCH-1:0] cnt_vld_q;
	logic [K_W-1:0] cnt_rd_q;
	logic           cnt_vld_rd_q;

	// cluster slot memory
	slot_t          slot_mem [NSLOT];
	slot_t          rd_q;
	slot_t          wr_d;
	logic [SL_AW-1:0] slot_addr;
	logic           slot_re, slot_we;

	logic [51:0] ref_q, win_q;
	logic [35:0] et_q;
	logic [55:0] ett_q;
	logic signed [32:0] ex_q, ey_q, ez_q;

	logic [19:0] mt_q, sp_q;
	logic [39:0] m2_q;
	res_t        res_q, out_q;
	res_t        res_init;
	logic        ovld_q;
	logic        out_free;

	logic [CH_AW-1:0] ch_idx;
	logic [6:0]       in_ch;

	// dividers: time, time squared, x, y, z
	logic [4:0]  div_start;
	logic [63:0] div_dvd [5];
	logic [63:0] div_quo [5];
	logic [4:0]  div_done;
	logic [31:0] div_den;
	logic        sq_start, sq_done;
	logic [31:0] sq_root;
	logic [63:0] sq_rad;

	logic        sx_neg, sy_neg, sz_neg;
	logic [47:0] sx_mag, sy_mag, sz_mag;

	assign in_ch  = s_axis_tdata[6:0];
	assign ch_idx = ch_q[CH_AW-1:0];
	assign slot_addr = SL_AW'(ch_idx) * SL_AW'(MAX_CLUSTERS) + SL_AW'(k_q);
	assign out_free  = !ovld_q || m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);
	assign slot_re = (state_q == S_RDI);
	assign slot_we = (state_q == S_WR);

	// config port
	assign pready = 1'b1;
	assign prdata = (paddr[2:2] == REG_TIME_WINDOW) ? {12'd0, tw_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tw_q <= TIME_WINDOW_RST;
		else if (psel && penable && pwrite && paddr[2:2] == REG_TIME_WINDOW)
			tw_q <= pwdata[19:0];
	end

	// memories
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_axis_tvalid)
			cnt_rd_q <= cnt_mem[in_ch[CH_AW-1:0]];
		if (state_q == S_WR && new_q)
			cnt_mem[ch_idx] <= n_q + K_W'(1);
		if (slot_re)
			rd_q <= slot_mem[slot_addr];
		if (slot_we)
			slot_mem[slot_addr] <= wr_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_q    <= '0;
			cnt_vld_rd_q <= 1'b0;
		end else begin
			if (state_q == S_IDLE && s_axis_tvalid)
				cnt_vld_rd_q <= cnt_vld_q[in_ch[CH_AW-1:0]];
			if (state_q == S_WR && new_q)
				cnt_vld_q[ch_idx] <= 1'b1;
			else if (state_q == S_CNT && req_q == REQ_FLUSH && in_rng_q)
				cnt_vld_q[ch_idx] <= 1'b0;
		end
	end

	// saturating update of a slot
	logic [31:0]        b_se;
	logic [55:0]        b_set;
	logic [63:0]        b_sq;
	logic signed [47:0] b_sx, b_sy, b_sz;
	logic [15:0]        b_hits;
	logic [32:0]        se_sum;
	logic [56:0]        set_sum;
	logic [64:0]        sq_sum;
	logic signed [48:0] sx_sum, sy_sum, sz_sum;

	function automatic logic signed [47:0] clamp48(logic signed [48:0] v);
		logic signed [47:0] r;
		if (v[48] != v[47])
			r = v[48] ? POS_SUM_MIN : POS_SUM_MAX;
		else
			r = v[47:0];
		return r;
	endfunction

	always_comb begin
		b_se   = new_q ? '0 : rd_q.se;
		b_set  = new_q ? '0 : rd_q.set;
		b_sq   = new_q ? '0 : rd_q.sq;
		b_sx   = new_q ? '0 : rd_q.sx;
		b_sy   = new_q ? '0 : rd_q.sy;
		b_sz   = new_q ? '0 : rd_q.sz;
		b_hits = new_q ? '0 : rd_q.hits;
		se_sum  = {1'b0, b_se} + {17'd0, e_q};
		set_sum = {1'b0, b_set} + {21'd0, et_q};
		sq_sum  = {1'b0, b_sq} + {9'd0, ett_q};
		sx_sum  = {b_sx[47], b_sx} + {{16{ex_q[32]}}, ex_q};
		sy_sum  = {b_sy[47], b_sy} + {{16{ey_q[32]}}, ey_q};
		sz_sum  = {b_sz[47], b_sz} + {{16{ez_q[32]}}, ez_q};
		wr_d.se   = se_sum[32] ? '1 : se_sum[31:0];
		wr_d.set  = set_sum[56] ? SET_MAX : set_sum[55:0];
		wr_d.sq   = sq_sum[64] ? '1 : sq_sum[63:0];
		wr_d.sx   = clamp48(sx_sum);
		wr_d.sy   = clamp48(sy_sum);
		wr_d.sz   = clamp48(sz_sum);
		wr_d.hits = (b_hits == '1) ? b_hits : b_hits + 16'd1;
	end

	// result for a hit, a dropped hit or an empty flush
	always_comb begin
		res_init      = '0;
		res_init.ch   = ch_q;
		res_init.last = 1'b1;
		if (req_q == REQ_HIT)
			res_init.status = (e_q == '0) ? ST_ZERO : ST_FULL;
		else
			res_init.status = ST_EMPTY;
	end

	// window compare
	logic [55:0] tdiff;
	logic        match;
	assign tdiff = (rd_q.set > {4'd0, ref_q}) ? rd_q.set - {4'd0, ref_q}
	                                          : {4'd0, ref_q} - rd_q.set;
	assign match = tdiff < {4'd0, win_q};

	// flush arithmetic
	assign div_den = (rd_q.se == '0) ? 32'd1 : rd_q.se;
	assign sx_neg  = rd_q.sx[47];
	assign sy_neg  = rd_q.sy[47];
	assign sz_neg  = rd_q.sz[47];
	assign sx_mag  = sx_neg ? 48'(-rd_q.sx) : 48'(rd_q.sx);
	assign sy_mag  = sy_neg ? 48'(-rd_q.sy) : 48'(rd_q.sy);
	assign sz_mag  = sz_neg ? 48'(-rd_q.sz) : 48'(rd_q.sz);
	assign div_dvd[0] = {8'd0, rd_q.set};
	assign div_dvd[1] = rd_q.sq;
	assign div_dvd[2] = {16'd0, sx_mag};
	assign div_dvd[3] = {16'd0, sy_mag};
	assign div_dvd[4] = {16'd0, sz_mag};
	assign div_start  = {5{state_q == S_FRD}};
	assign sq_rad     = div_quo[1] - {24'd0, m2_q};
	assign sq_start   = (state_q == S_FSQ2) && (rd_q.hits > 16'd1)
	                    && (div_quo[1] > {24'd0, m2_q});

	for (genvar g = 0; g < 5; g++) begin : g_div
		hptc_div u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.start    (div_start[g]),
			.dividend (div_dvd[g]),
			.divisor  (div_den),
			.quotient (div_quo[g]),
			.done     (div_done[g])
		);
	end

	hptc_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (sq_rad),
		.root     (sq_root),
		.done     (sq_done)
	);

	function automatic logic [15:0] mean_pos(logic neg, logic [63:0] q);
		logic [15:0] r;
		if (!neg)
			r = (q > 64'd32767) ? 16'h7fff : q[15:0];
		else
			r = (q > 64'd32768) ? 16'h8000 : 16'(-q[15:0]);
		return r;
	endfunction

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			ovld_q  <= 1'b0;
			k_q     <= '0;
			n_q     <= '0;
			new_q   <= 1'b0;
		end else begin
			if (state_q == S_OUT && out_free)
				ovld_q <= 1'b1;
			else if (m_axis_tready)
				ovld_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid)
						state_q <= S_CNT;
				end
				S_CNT: begin
					n_q   <= (in_rng_q && cnt_vld_rd_q) ? cnt_rd_q : '0;
					k_q   <= '0;
					new_q <= (req_q == REQ_HIT) && (e_q != '0) && in_rng_q
					         && (!cnt_vld_rd_q || cnt_rd_q == '0);
					ret_q <= S_IDLE;
					if (req_q == REQ_HIT) begin
						if (e_q == '0 || !in_rng_q)
							state_q <= S_OUT;
						else if (!cnt_vld_rd_q || cnt_rd_q == '0)
							state_q <= S_MUL1;
						else
							state_q <= S_RDI;
					end else begin
						if (!in_rng_q || !cnt_vld_rd_q || cnt_rd_q == '0)
							state_q <= S_OUT;
						else
							state_q <= S_RDI;
					end
				end
				S_RDI: state_q <= (req_q == REQ_HIT) ? S_RD : S_FRD;
				S_RD:  state_q <= S_CMP;
				S_CMP: begin
					if (match)
						state_q <= S_MUL1;
					else if (k_q + K_W'(1) == n_q) begin
						if (n_q == K_W'(MAX_CLUSTERS))
							state_q <= S_OUT;
						else begin
							k_q     <= n_q;
							new_q   <= 1'b1;
							state_q <= S_MUL1;
						end
					end else begin
						k_q     <= k_q + K_W'(1);
						state_q <= S_RDI;
					end
				end
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_WR;
				S_WR:   state_q <= S_OUT;
				S_OUT: begin
					if (out_free)
						state_q <= ret_q;
				end
				S_FRD: state_q <= S_FDIV;
				S_FDIV: begin
					if (div_done[0])
						state_q <= S_FSQ1;
				end
				S_FSQ1: state_q <= S_FSQ2;
				S_FSQ2: state_q <= sq_start ? S_FSQRT : S_FRES;
				S_FSQRT: begin
					if (sq_done)
						state_q <= S_FRES;
				end
				S_FRES: begin
					k_q     <= k_q + K_W'(1);
					ret_q   <= (k_q + K_W'(1) == n_q) ? S_IDLE : S_RDI;
					state_q <= S_OUT;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_axis_tvalid) begin
			req_q    <= s_axis_tuser;
			ch_q     <= in_ch;
			t_q      <= s_axis_tdata[26:7];
			e_q      <= s_axis_tdata[42:27];
			px_q     <= s_axis_tdata[58:43];
			py_q     <= s_axis_tdata[74:59];
			pz_q     <= s_axis_tdata[90:75];
			in_rng_q <= 32'(in_ch) < NCH;
		end
		if (state_q == S_RD) begin
			ref_q <= 52'(t_q) * 52'(rd_q.se);
			win_q <= 52'(tw_q) * 52'(rd_q.se);
		end
		if (state_q == S_MUL1) begin
			et_q <= 36'(e_q) * 36'(t_q);
			ex_q <= $signed({1'b0, e_q}) * px_q;
			ey_q <= $signed({1'b0, e_q}) * py_q;
			ez_q <= $signed({1'b0, e_q}) * pz_q;
		end
		if (state_q == S_MUL2)
			ett_q <= 56'(et_q) * 56'(t_q);
		if (state_q == S_FDIV && div_done[0])
			mt_q <= (div_quo[0] > 64'(T_MAX)) ? T_MAX : div_quo[0][19:0];
		if (state_q == S_FSQ1)
			m2_q <= 40'(mt_q) * 40'(mt_q);
		if (state_q == S_FSQ2)
			sp_q <= '0;
		if (state_q == S_FSQRT && sq_done)
			sp_q <= (sq_root > 32'(T_MAX)) ? T_MAX : sq_root[19:0];

		case (state_q)
			S_CNT: res_q <= res_init;
			S_CMP: res_q.status <= ST_FULL;
			S_WR:  res_q.status <= new_q ? ST_NEW : ST_MERGED;
			S_FRES: begin
				res_q.status <= ST_CLUS;
				res_q.ch     <= ch_q;
				res_q.mt     <= mt_q;
				res_q.sp     <= sp_q;
				res_q.esum   <= rd_q.se;
				res_q.mx     <= mean_pos(sx_neg, div_quo[2]);
				res_q.my     <= mean_pos(sy_neg, div_quo[3]);
				res_q.mz     <= mean_pos(sz_neg, div_quo[4]);
				res_q.hits   <= rd_q.hits;
				res_q.last   <= (k_q + K_W'(1) == n_q);
			end
			default: ;
		endcase

		if (state_q == S_OUT && out_free)
			out_q <= res_q;
	end

	assign m_axis_tvalid = ovld_q;
	assign m_axis_tuser  = out_q.status;
	assign m_axis_tlast  = out_q.last;
	assign m_axis_tdata  = {1'b0, out_q.hits, out_q.mz, out_q.my, out_q.mx,
	                        out_q.esum, out_q.sp, out_q.mt, out_q.ch};

	// the five dividers run in lockstep
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(div_done) == 0 || $countones(div_done) == 5)
		else $error("dividers out of step");

	// the cluster walk never passes the channel's count
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP || state_q == S_FRD) |-> k_q < n_q)
		else $error("cluster index past count");

	// an accepted beat always starts with the count lookup
	a_accept_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> state_q == S_CNT)
		else $error("accept did not start lookup");

endmodule

// File: sim/per_channel_hit_time_clustering_core_tb.sv
module per_channel_hit_time_clustering_core_tb import hptc_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NCH = 128;
	localparam int NCL = 8;
	localparam int CYCLE_LIMIT = 800000;

	typedef struct packed {
		logic [0:0]  req;
		logic [6:0]  ch;
		logic [19:0] t;
		logic [15:0] e;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] z;
	} hit_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_valid = 1'b0;
	logic s_axis_tready;
	hit_req_t cur = '0;
	logic m_axis_tvalid;
	logic m_ready = 1'b0;
	logic [143:0] m_axis_tdata;
	logic [2:0] m_axis_tuser;
	logic m_axis_tlast;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	always #5 clk = ~clk;

	per_channel_hit_time_clustering_core u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_valid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata({5'd0, cur.z, cur.y, cur.x, cur.e, cur.t, cur.ch}),
		.s_axis_tuser(cur.req),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_ready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// shadow cluster table
	logic [19:0] win = TIME_WINDOW_RST;
	int unsigned clus_cnt [NCH];
	longint unsigned acc_e [NCH*NCL];
	longint unsigned acc_et [NCH*NCL];
	longint unsigned acc_ett [NCH*NCL];
	longint acc_ex [NCH*NCL];
	longint acc_ey [NCH*NCL];
	longint acc_ez [NCH*NCL];
	int unsigned acc_hits [NCH*NCL];

	hit_req_t pending [$];
	res_t cluster_results [$];
	int errors = 0;
	int n_hits = 0, n_flush = 0, n_results = 0;
	int cycles = 0;
	int gap = 0, stall = 0, long_hold = 0;
	bit no_idle = 0, hold_go = 0, hold_done = 0;

	function automatic longint unsigned sat_u(longint unsigned a, longint unsigned b,
			longint unsigned mx);
		if (a > mx) a = mx;
		if (b > mx - a) return mx;
		return a + b;
	endfunction

	function automatic longint sat_s48(longint a, longint b);
		longint r;
		r = a + b;
		if (r > longint'(POS_SUM_MAX)) r = longint'(POS_SUM_MAX);
		if (r < longint'(POS_SUM_MIN)) r = longint'(POS_SUM_MIN);
		return r;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, one;
		res = 0;
		one = 64'd1 << 62;
		while (one > v) one >>= 2;
		while (one != 0) begin
			if (v >= res + one) begin
				v -= res + one;
				res = (res >> 1) + one;
			end else begin
				res >>= 1;
			end
			one >>= 2;
		end
		return res;
	endfunction

	function automatic logic [15:0] mean_coord(longint s, longint unsigned e);
		longint m;
		m = s / longint'(e);
		if (m > 32767) m = 32767;
		if (m < -32768) m = -32768;
		return m[15:0];
	endfunction

	function automatic void clear_slot(int s);
		acc_e[s] = 0; acc_et[s] = 0; acc_ett[s] = 0;
		acc_ex[s] = 0; acc_ey[s] = 0; acc_ez[s] = 0; acc_hits[s] = 0;
	endfunction

	task automatic cluster_predict(hit_req_t h);
		res_t r;
		int n, k, s, base;
		longint unsigned se, rf, d, mt, sp, q, m2, e, t;
		r = '0;
		r.ch = h.ch;
		base = int'(h.ch) * NCL;
		n = clus_cnt[h.ch];
		e = 64'(h.e);
		t = 64'(h.t);
		if (h.req == REQ_HIT) begin
			n_hits++;
			r.last = 1'b1;
			if (h.e == 0) begin
				r.status = ST_ZERO;
			end else begin
				for (k = 0; k < n; k++) begin
					se = acc_e[base+k];
					rf = t * se;
					d = acc_et[base+k] > rf ? acc_et[base+k] - rf : rf - acc_et[base+k];
					if (d < longint'(win) * se) break;
				end
				if (k == n && n >= NCL) begin
					r.status = ST_FULL;
				end else begin
					if (k == n) begin
						clear_slot(base + k);
						clus_cnt[h.ch] = n + 1;
						r.status = ST_NEW;
					end else begin
						r.status = ST_MERGED;
					end
					s = base + k;
					acc_e[s] = sat_u(acc_e[s], e, 64'hFFFF_FFFF);
					acc_et[s] = sat_u(acc_et[s], e * t, longint'(SET_MAX));
					acc_ett[s] = sat_u(acc_ett[s], e * t * t, 64'hFFFF_FFFF_FFFF_FFFF);
					acc_ex[s] = sat_s48(acc_ex[s], longint'(e) * longint'($signed(h.x)));
					acc_ey[s] = sat_s48(acc_ey[s], longint'(e) * longint'($signed(h.y)));
					acc_ez[s] = sat_s48(acc_ez[s], longint'(e) * longint'($signed(h.z)));
					if (acc_hits[s] < 16'hFFFF) acc_hits[s]++;
				end
			end
			cluster_results.insert(cluster_results.size(), r);
		end else begin
			n_flush++;
			if (n == 0) begin
				r.status = ST_EMPTY;
				r.last = 1'b1;
				cluster_results.insert(cluster_results.size(), r);
			end
			for (k = 0; k < n; k++) begin
				s = base + k;
				se = acc_e[s] == 0 ? 1 : acc_e[s];
				mt = acc_et[s] / se;
				if (mt > T_MAX) mt = T_MAX;
				sp = 0;
				if (acc_hits[s] > 1) begin
					q = acc_ett[s] / se;
					m2 = mt * mt;
					sp = q > m2 ? int_sqrt(q - m2) : 0;
					if (sp > T_MAX) sp = T_MAX;
				end
				r.status = ST_CLUS;
				r.mt = mt[19:0];
				r.sp = sp[19:0];
				r.esum = acc_e[s][31:0];
				r.mx = mean_coord(acc_ex[s], se);
				r.my = mean_coord(acc_ey[s], se);
				r.mz = mean_coord(acc_ez[s], se);
				r.hits = acc_hits[s][15:0];
				r.last = (k + 1 == n);
				cluster_results.insert(cluster_results.size(), r);
				clear_slot(s);
			end
			clus_cnt[h.ch] = 0;
		end
	endtask

	// sender
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n) begin
			if (s_valid && s_axis_tready) begin
				cluster_predict(cur);
				if (!no_idle && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 6);
			end
			if (!s_valid || s_axis_tready) begin
				if (gap > 0) begin
					gap = gap - 1;
					s_valid <= 1'b0;
				end else if (pending.size() > 0) begin
					cur <= pending.pop_front();
					s_valid <= 1'b1;
				end else begin
					s_valid <= 1'b0;
				end
			end
		end
	end

	// receiver
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_go && !hold_done) begin
				hold_done <= 1'b1;
				long_hold <= 400;
				m_ready <= 1'b0;
			end else if (long_hold > 0) begin
				long_hold <= long_hold - 1;
				m_ready <= 1'b0;
			end else if (stall > 0) begin
				stall <= stall - 1;
				m_ready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 4) == 0) begin
				stall <= $urandom_range(0, 5);
				m_ready <= 1'b0;
			end else begin
				m_ready <= 1'b1;
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		res_t w;
		if (arst_n && m_axis_tvalid && m_ready) begin
			n_results++;
			if (cluster_results.size() == 0) begin
				$error("unexpected result beat, status %0d", m_axis_tuser);
				errors++;
			end else begin
				w = cluster_results.pop_front();
				if (m_axis_tuser !== w.status) begin
					$error("status exp %0d got %0d", w.status, m_axis_tuser); errors++;
				end
				if (m_axis_tdata[6:0] !== w.ch) begin
					$error("out_channel exp %0d got %0d", w.ch, m_axis_tdata[6:0]); errors++;
				end
				if (m_axis_tdata[26:7] !== w.mt) begin
					$error("mean_time exp %0d got %0d", w.mt, m_axis_tdata[26:7]); errors++;
				end
				if (m_axis_tdata[46:27] !== w.sp) begin
					$error("time_spread exp %0d got %0d", w.sp, m_axis_tdata[46:27]); errors++;
				end
				if (m_axis_tdata[78:47] !== w.esum) begin
					$error("energy_sum exp %0d got %0d", w.esum, m_axis_tdata[78:47]);
					errors++;
				end
				if (m_axis_tdata[94:79] !== w.mx) begin
					$error("mean_x exp %0d got %0d", $signed(w.mx),
						$signed(m_axis_tdata[94:79])); errors++;
				end
				if (m_axis_tdata[110:95] !== w.my) begin
					$error("mean_y exp %0d got %0d", $signed(w.my),
						$signed(m_axis_tdata[110:95])); errors++;
				end
				if (m_axis_tdata[126:111] !== w.mz) begin
					$error("mean_z exp %0d got %0d", $signed(w.mz),
						$signed(m_axis_tdata[126:111])); errors++;
				end
				if (m_axis_tdata[142:127] !== w.hits) begin
					$error("hit_count exp %0d got %0d", w.hits, m_axis_tdata[142:127]);
					errors++;
				end
				if (m_axis_tlast !== w.last) begin
					$error("last exp %0d got %0d", w.last, m_axis_tlast); errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILED: results differ");
			$finish;
		end
	end

	task automatic write_window(logic [19:0] v);
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'(REG_TIME_WINDOW) * 3'd4;
		pwdata <= {12'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		win = v;
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		@(posedge clk);
		psel <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[19:0] !== v) begin
			$error("time_window readback exp %0d got %0d", v, prdata[19:0]);
			errors++;
		end
		psel <= 1'b0; penable <= 1'b0;
	endtask

	task automatic add_item(logic [0:0] rq, logic [6:0] ch, logic [19:0] t, logic [15:0] e,
			logic [15:0] x, logic [15:0] y, logic [15:0] z);
		hit_req_t h;
		h = '{req: rq, ch: ch, t: t, e: e, x: x, y: y, z: z};
		pending.insert(pending.size(), h);
	endtask

	task automatic drain();
		wait (pending.size() == 0 && !s_valid && cluster_results.size() == 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic random_items(int cnt);
		logic [19:0] base [4];
		logic [6:0] ch;
		logic [15:0] e;
		int i;
		for (i = 0; i < 4; i++) base[i] = 20'($urandom);
		for (i = 0; i < cnt; i++) begin
			ch = $urandom_range(0, 9) == 0 ? 7'($urandom) : 7'($urandom_range(0, 3));
			if ($urandom_range(0, 7) == 0) begin
				add_item(REQ_FLUSH, ch, 20'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom));
			end else begin
				if ($urandom_range(0, 9) == 0) base[ch[1:0]] = 20'($urandom);
				case ($urandom_range(0, 19))
					0: e = 16'd0;
					1: e = 16'hFFFF;
					default: e = 16'($urandom);
				endcase
				add_item(REQ_HIT, ch, base[ch[1:0]] + 20'($urandom_range(0, 150)), e,
					16'($urandom), 16'($urandom), 16'($urandom));
			end
		end
	endtask

	initial begin
		int i;
		for (i = 0; i < NCH; i++) clus_cnt[i] = 0;
		for (i = 0; i < NCH*NCL; i++) clear_slot(i);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: field extremes, zero energy, full table, empty flush
		write_window(20'd80);
		add_item(REQ_HIT, 7'd0, 20'd0, 16'd1, 16'h8000, 16'h8000, 16'h8000);
		add_item(REQ_HIT, 7'd0, 20'd10, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		add_item(REQ_HIT, 7'd0, 20'd20, 16'd0, 16'h1234, 16'h0, 16'h0);
		add_item(REQ_HIT, 7'd127, 20'hFFFFF, 16'hFFFF, 16'h8000, 16'h7FFF, 16'hFFFF);
		add_item(REQ_HIT, 7'd127, 20'hFFFF0, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0001);
		for (i = 0; i < 9; i++)
			add_item(REQ_HIT, 7'd5, 20'(i * 1000), 16'd3, 16'(i), 16'(-i), 16'd0);
		add_item(REQ_HIT, 7'd5, 20'd1005, 16'd7, 16'd1, 16'd2, 16'd3);
		add_item(REQ_FLUSH, 7'd5, 20'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		add_item(REQ_FLUSH, 7'd5, 20'hFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		add_item(REQ_FLUSH, 7'd127, 20'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		add_item(REQ_FLUSH, 7'd0, 20'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		add_item(REQ_FLUSH, 7'd9, 20'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		drain();

		write_window(20'hFFFFF);
		random_items(50);
		drain();

		// receiver holds off while the sender keeps going
		write_window(20'd1);
		hold_go = 1'b1;
		random_items(50);
		drain();

		write_window(20'd0);
		random_items(30);
		drain();

		write_window(20'($urandom_range(20, 400)));
		random_items(50);
		drain();

		no_idle = 1'b1;
		write_window(20'd80);
		random_items(20);
		for (i = 0; i < 4; i++) add_item(REQ_FLUSH, 7'(i), 20'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		drain();

		$display("covered %0d hits and %0d flushes, %0d result beats checked",
			n_hits, n_flush, n_results);
		$display("windows 80, max, 1, 0 and random, with stalls and a long hold-off");
		if (errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// File: filelist.f
hdl/hptc_pkg.sv
hdl/hptc_div.sv
hdl/hptc_isqrt.sv
hdl/per_channel_hit_time_clustering_core.sv
sim/per_channel_hit_time_clustering_core_tb.sv
